@@ src/fed_pkg.sv @@
package fed_pkg;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 18;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_DELAY    = 2'd1,
    CFG_FEEDBACK = 2'd2,
    CFG_WET      = 2'd3
  } cfg_idx_t;

  // register widths
  localparam int DELAY_W = 18;
  localparam int GAIN_W  = 16;
  localparam int WET_W   = 17;

  // Q1.16 constants
  localparam int Q16_SHIFT = 16;
  localparam logic [WET_W-1:0] UNITY_Q16 = 17'h10000;
  localparam int HALF_Q16 = 32768;

  // reset values
  localparam int DELAY_RST = 24000;
  localparam logic [WET_W-1:0] WET_RST = 17'd32768;

endpackage

@@ src/feedback_echo_delay_core.sv @@
// Channel  | Dir | Transaction fields
// ---------+-----+--------------------------------------------------------------
// in_*     | in  | tuser: channel_index; tdata: in_sample (zero padded to bytes)
// out_*    | out | tdata: out_sample (zero padded to bytes)
// cfg_*    | in  | cfg_addr selects enable/delay/feedback/wet, cfg_wdata value
//
// One sample per cycle sustained unless stalled; each sample passes the stage 1,
// stage 2 and output registers. The echo memory has one write and one registered
// read port; a one-entry forwarding register covers the write still in flight
// when a delay of one sample reads it back. A per-channel fill count marks slots
// never written as zero, so reset needs no memory clearing pass. A waiting sample
// with out_tready low stalls every stage together; in_tready follows it directly.
module feedback_echo_delay_core #(
  parameter int MAX_DELAY   = 262144,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tuser: [CW-1:0] channel_index
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] in_tuser,
  // tdata: [SAMPLE_BITS-1:0] in_sample, rest zero
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: [SAMPLE_BITS-1:0] out_sample, rest zero
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [fed_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [fed_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int SB        = SAMPLE_BITS;
  localparam int DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW        = $clog2(MAX_DELAY);
  localparam int DW        = $clog2(MAX_DELAY + 1);
  localparam int XW        = DW + 1;
  localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int FBW       = SB + fed_pkg::GAIN_W + 1;
  localparam int MXW       = SB + fed_pkg::WET_W + 1;
  localparam int DLY_RST   = (fed_pkg::DELAY_RST > MAX_DELAY) ? MAX_DELAY : fed_pkg::DELAY_RST;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic                        enable_r;
  logic [DW-1:0]               dly_r;
  logic [fed_pkg::GAIN_W-1:0]  gain_r;
  logic [fed_pkg::WET_W-1:0]   wet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      dly_r    <= DW'(DLY_RST);
      gain_r   <= '0;
      wet_r    <= fed_pkg::WET_RST;
    end else if (cfg_we) begin
      case (fed_pkg::cfg_idx_t'(cfg_addr))
        fed_pkg::CFG_ENABLE: enable_r <= cfg_wdata[0];
        fed_pkg::CFG_DELAY: begin
          if (cfg_wdata[fed_pkg::DELAY_W-1:0] == '0)
            dly_r <= DW'(1);
          else if (int'(cfg_wdata[fed_pkg::DELAY_W-1:0]) > MAX_DELAY)
            dly_r <= DW'(MAX_DELAY);
          else
            dly_r <= DW'(cfg_wdata[fed_pkg::DELAY_W-1:0]);
        end
        fed_pkg::CFG_FEEDBACK: gain_r <= cfg_wdata[fed_pkg::GAIN_W-1:0];
        fed_pkg::CFG_WET: begin
          if (cfg_wdata[fed_pkg::WET_W-1:0] > fed_pkg::UNITY_Q16)
            wet_r <= fed_pkg::UNITY_Q16;
          else
            wet_r <= cfg_wdata[fed_pkg::WET_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic out_valid_r;
  logic advance;
  logic accept;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = rst_n && advance;
  assign accept    = in_tvalid && in_tready;

  // ---------------------------------------------------------------- stage 0
  logic [CW-1:0]  ch;
  logic [PW-1:0]  wp_r   [CHANNELS];
  logic           wrap_r [CHANNELS];
  logic [PW-1:0]  wp_cur;
  logic           wrap_cur;
  logic [PW-1:0]  wp_nxt;
  logic signed [XW-1:0] rd_diff;
  logic [PW-1:0]  rd_pos;
  logic           rd_written;
  logic [AW-1:0]  ch_base;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;

  always_comb begin
    // channel index modulo CHANNELS; the raw code is below twice the count
    if (int'(in_tuser) >= CHANNELS)
      ch = in_tuser - CW'(CHANNELS);
    else
      ch = in_tuser;
    wp_cur   = wp_r[ch];
    wrap_cur = wrap_r[ch];
    wp_nxt   = (wp_cur == PW'(MAX_DELAY - 1)) ? '0 : wp_cur + PW'(1);
    rd_diff  = $signed(XW'(wp_cur)) - $signed(XW'(dly_r));
    rd_pos   = rd_diff[XW-1] ? PW'(rd_diff + XW'(MAX_DELAY)) : PW'(rd_diff);
    // slots at or past the fill point were never written until the first wrap
    rd_written = wrap_cur || (rd_pos < wp_cur);
    ch_base  = AW'(ch) * AW'(MAX_DELAY);
    rd_addr  = ch_base + AW'(rd_pos);
    wr_addr  = ch_base + AW'(wp_cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i]   <= '0;
        wrap_r[i] <= 1'b0;
      end
    end else if (accept && enable_r) begin
      wp_r[ch] <= wp_nxt;
      if (wp_nxt == '0)
        wrap_r[ch] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                 s1_valid_r;
  logic                 s1_en_r;
  logic signed [SB-1:0] s1_dry_r;
  logic [AW-1:0]        s1_waddr_r;
  logic [AW-1:0]        s1_raddr_r;
  logic                 s1_rvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_en_r     <= enable_r;
      s1_dry_r    <= $signed(in_tdata[SB-1:0]);
      s1_waddr_r  <= wr_addr;
      s1_raddr_r  <= rd_addr;
      s1_rvalid_r <= rd_written;
    end
  end

  // echo memory
  logic [SB-1:0] echo_mem [MEM_DEPTH];
  logic [SB-1:0] mem_q_r;
  logic          mem_we;
  logic signed [SB-1:0] fb_sat;

  assign mem_we = advance && s1_valid_r && s1_en_r;

  always_ff @(posedge clk) begin
    if (mem_we)
      echo_mem[s1_waddr_r] <= fb_sat;
    if (advance)
      mem_q_r <= echo_mem[rd_addr];
  end

  // last write, forwarded to a read issued in the same cycle
  logic          lw_valid_r;
  logic [AW-1:0] lw_addr_r;
  logic [SB-1:0] lw_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (advance) begin
      lw_valid_r <= s1_valid_r && s1_en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lw_addr_r <= s1_waddr_r;
      lw_data_r <= fb_sat;
    end
  end

  logic signed [SB-1:0]  delayed;
  logic signed [FBW-1:0] fb_prod;
  logic signed [FBW-1:0] fb_biased;
  logic signed [SB:0]    fb_rnd;
  logic signed [SB+1:0]  fb_sum;
  logic [fed_pkg::WET_W-1:0] dry_w;
  logic signed [MXW-1:0] dry_prod;
  logic signed [MXW-1:0] wet_prod;

  always_comb begin
    if (lw_valid_r && (lw_addr_r == s1_raddr_r))
      delayed = $signed(lw_data_r);
    else if (s1_rvalid_r)
      delayed = $signed(mem_q_r);
    else
      delayed = '0;

    fb_prod   = delayed * $signed({1'b0, gain_r});
    fb_biased = fb_prod + FBW'(fed_pkg::HALF_Q16);
    fb_rnd    = fb_biased[FBW-1:fed_pkg::Q16_SHIFT];
    fb_sum    = (SB+2)'(s1_dry_r) + (SB+2)'(fb_rnd);
    if (fb_sum[SB+1:SB-1] == '0 || fb_sum[SB+1:SB-1] == '1)
      fb_sat = fb_sum[SB-1:0];
    else
      fb_sat = fb_sum[SB+1] ? S_MIN : S_MAX;

    dry_w    = fed_pkg::UNITY_Q16 - wet_r;
    dry_prod = s1_dry_r * $signed({1'b0, dry_w});
    wet_prod = delayed * $signed({1'b0, wet_r});
  end

  // ---------------------------------------------------------------- stage 2
  logic                  p_valid_r;
  logic                  p_en_r;
  logic signed [SB-1:0]  p_dry_r;
  logic signed [MXW-1:0] p_dry_prod_r;
  logic signed [MXW-1:0] p_wet_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (advance) begin
      p_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_en_r       <= s1_en_r;
      p_dry_r      <= s1_dry_r;
      p_dry_prod_r <= dry_prod;
      p_wet_prod_r <= wet_prod;
    end
  end

  logic signed [MXW:0]  mix_sum;
  logic signed [SB+2:0] mix_rnd;
  logic signed [SB-1:0] out_nxt;

  always_comb begin
    mix_sum = (MXW+1)'(p_dry_prod_r) + (MXW+1)'(p_wet_prod_r)
            + (MXW+1)'(fed_pkg::HALF_Q16);
    mix_rnd = mix_sum[MXW:fed_pkg::Q16_SHIFT];
    if (!p_en_r)
      out_nxt = p_dry_r;
    else if (mix_rnd[SB+2:SB-1] == '0 || mix_rnd[SB+2:SB-1] == '1)
      out_nxt = mix_rnd[SB-1:0];
    else
      out_nxt = mix_rnd[SB+2] ? S_MIN : S_MAX;
  end

  // ---------------------------------------------------------------- output
  logic [SB-1:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance)
      out_sample_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_sample_r);

endmodule

@@ src/fed_port_checker.sv @@
module fed_port_checker #(
  parameter int DATA_W = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [DATA_W-1:0]          out_tdata
);

  // input side stalls exactly when a finished sample waits downstream
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not track output stall");

  // an accepted transaction reaches the output if the pipeline keeps advancing
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 in_tready ##1 in_tready |=> out_tvalid)
    else $error("result missing three cycles after transaction");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

endmodule

bind feedback_echo_delay_core fed_port_checker #(
  .DATA_W(((SAMPLE_BITS + 7) / 8) * 8)
) u_fed_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
